### design/nnis_pkg.sv
package nnis_pkg;

  localparam int MAX_DIM_DEF      = 1024;
  localparam int STORE_PIXELS_DEF = 1048576;

  localparam int FRAC_BITS = 16;
  localparam int ACC_W     = 27;
  localparam int CFG_W     = 11;
  localparam int IDX_W     = 2;
  localparam int PIX_W     = 32;
  localparam int POS_W     = 10;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  typedef enum logic [IDX_W-1:0] {
    REG_SRC_W,
    REG_SRC_H,
    REG_DST_W,
    REG_DST_H
  } cfg_reg_e;

  localparam logic [CFG_W-1:0] SRC_W_RST = CFG_W'(864);
  localparam logic [CFG_W-1:0] SRC_H_RST = CFG_W'(480);
  localparam logic [CFG_W-1:0] DST_W_RST = CFG_W'(864);
  localparam logic [CFG_W-1:0] DST_H_RST = CFG_W'(480);

endpackage

### design/nearest_neighbor_image_scaler.sv
// Nearest-neighbour scaler for 32-bit pixels.
// Input channel (in_valid_i / in_stall_o) carries a command and a pixel word.
// A load item writes pixel_in_i into the frame store at the next raster
// position and gives no result. A fetch item gives one result item on the
// output channel (out_valid_o / out_stall_i): the source pixel for the next
// destination position, its column and row, and row and frame end flags.
// A fetch passes from acceptance to the result register through clamp,
// address multiply, frame store read and result write. The first fetch of
// a frame first runs the two 11.16 step divisions, done one bit a cycle on
// a shared restoring divide unit. When STORE_PIXELS is not a power of two
// and smaller than MAX_DIM squared, the address reduction runs on the same
// unit between address multiply and frame store read.
// in_stall_o is high while a fetch is worked on: no item is taken until it
// is done, and one load is taken every cycle while no fetch is worked on.
// Reset clears counters, accumulators and steps and sets sizes to 864 x 480;
// store contents are undefined until loaded. A stalled result holds in the
// output register; the next item is still taken, and a fetch waits at the
// end until the register frees.
// Size registers are written on the cfg channel, index 0..3, always ready.
module nearest_neighbor_image_scaler
  import nnis_pkg::*;
#(
  parameter int MAX_DIM      = MAX_DIM_DEF,
  parameter int STORE_PIXELS = STORE_PIXELS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             command_i,
  input  logic [PIX_W-1:0] pixel_in_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [PIX_W-1:0] pixel_out_o,
  output logic [POS_W-1:0] out_column_o,
  output logic [POS_W-1:0] out_row_o,
  output logic             row_end_o,
  output logic             frame_end_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  localparam int DW   = $clog2(MAX_DIM + 1);
  localparam int CW   = $clog2(MAX_DIM);
  localparam int LW   = $clog2(MAX_DIM * MAX_DIM);
  localparam int PW   = CW + DW;
  localparam int SAW  = $clog2(STORE_PIXELS);
  localparam int XW   = (DW > ACC_W - FRAC_BITS) ? DW : ACC_W - FRAC_BITS;
  localparam int RW   = ((DW > SAW) ? DW : SAW) + 1;
  localparam int NW   = (DW + FRAC_BITS > LW) ? DW + FRAC_BITS : LW;
  localparam int NCW  = $clog2(NW + 1);
  localparam bit POW2 = (STORE_PIXELS & (STORE_PIXELS - 1)) == 0;
  localparam bit NEED_MOD = !POW2 && (MAX_DIM * MAX_DIM > STORE_PIXELS);
  localparam logic [RW-1:0]  STORE_C  = RW'(STORE_PIXELS);
  localparam logic [SAW-1:0] STORE_M1 = SAW'(STORE_PIXELS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_X,
    ST_DIV_Y,
    ST_CLAMP,
    ST_ADDR,
    ST_MOD,
    ST_READ,
    ST_RESULT
  } state_e;

  function automatic logic [DW-1:0] eff_dim(input logic [CFG_W-1:0] v);
    if (v == '0) begin
      return DW'(1);
    end else if (32'(v) > MAX_DIM) begin
      return DW'(MAX_DIM);
    end else begin
      return DW'(v);
    end
  endfunction

  state_e state_q;

  logic [CFG_W-1:0] src_w_q, src_h_q, dst_w_q, dst_h_q;
  logic [DW-1:0]    sw, sh, dw, dh;

  logic [PIX_W-1:0] frame_store_q [STORE_PIXELS];
  logic [PIX_W-1:0] rd_q;

  logic [LW-1:0]    load_pos_q;
  logic [SAW-1:0]   store_pos_q;
  logic [CW-1:0]    col_q, row_q;
  logic [ACC_W-1:0] x_acc_q, y_acc_q, x_step_q, y_step_q;
  logic [CW-1:0]    sx_q, sy_q;
  logic [SAW-1:0]   addr_q;

  logic [RW-1:0]    div_rem_q;
  logic [NW-1:0]    div_dvd_q;
  logic [ACC_W-1:0] div_quo_q;
  logic [NCW-1:0]   div_cnt_q;

  logic             out_valid_q, row_end_q, frame_end_q;
  logic [PIX_W-1:0] pixel_out_q;
  logic [POS_W-1:0] out_col_q, out_row_q;

  logic             in_acc;
  logic [2*DW-1:0]  frame_pixels, load_next;
  logic             load_wrap;
  logic [RW-1:0]    shifted, divisor, rem_d;
  logic [RW:0]      diff;
  logic             ge;
  logic [ACC_W-1:0] quo_d, step_d;
  logic [XW-1:0]    sx_raw, sy_raw, sw_m1, sh_m1;
  logic [PW-1:0]    lin_full;
  logic [LW-1:0]    lin;
  logic             last_col, last_row, out_free;

  assign sw = eff_dim(src_w_q);
  assign sh = eff_dim(src_h_q);
  assign dw = eff_dim(dst_w_q);
  assign dh = eff_dim(dst_h_q);

  assign in_stall_o  = state_q != ST_IDLE;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign frame_pixels = (2*DW)'(sw) * (2*DW)'(sh);
  assign load_next    = (2*DW)'(load_pos_q) + (2*DW)'(1);
  assign load_wrap    = load_next >= frame_pixels;

  // shared restoring divide step
  assign shifted = {div_rem_q[RW-2:0], div_dvd_q[NW-1]};
  always_comb begin
    unique case (state_q)
      ST_DIV_X: divisor = RW'(dw);
      ST_DIV_Y: divisor = RW'(dh);
      default:  divisor = STORE_C;
    endcase
  end
  assign diff   = {1'b0, shifted} - {1'b0, divisor};
  assign ge     = !diff[RW];
  assign rem_d  = ge ? diff[RW-1:0] : shifted;
  assign quo_d  = {div_quo_q[ACC_W-2:0], ge};
  assign step_d = quo_d + ACC_W'(1);

  assign sx_raw = XW'(x_acc_q[ACC_W-1:FRAC_BITS]);
  assign sy_raw = XW'(y_acc_q[ACC_W-1:FRAC_BITS]);
  assign sw_m1  = XW'(sw) - XW'(1);
  assign sh_m1  = XW'(sh) - XW'(1);

  assign lin_full = PW'(sy_q) * PW'(sw) + PW'(sx_q);
  assign lin      = LW'(lin_full);

  assign last_col = (DW'(col_q) + DW'(1)) >= dw;
  assign last_row = (DW'(row_q) + DW'(1)) >= dh;
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_acc && command_i == CMD_LOAD) begin
      frame_store_q[store_pos_q] <= pixel_in_i;
    end
    if (state_q == ST_READ) begin
      rd_q <= frame_store_q[addr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      src_w_q     <= SRC_W_RST;
      src_h_q     <= SRC_H_RST;
      dst_w_q     <= DST_W_RST;
      dst_h_q     <= DST_H_RST;
      load_pos_q  <= '0;
      store_pos_q <= '0;
      col_q       <= '0;
      row_q       <= '0;
      x_acc_q     <= '0;
      y_acc_q     <= '0;
      x_step_q    <= '0;
      y_step_q    <= '0;
      sx_q        <= '0;
      sy_q        <= '0;
      addr_q      <= '0;
      div_rem_q   <= '0;
      div_dvd_q   <= '0;
      div_quo_q   <= '0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      row_end_q   <= 1'b0;
      frame_end_q <= 1'b0;
      pixel_out_q <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_reg_e'(cfg_index_i))
          REG_SRC_W: src_w_q <= cfg_data_i;
          REG_SRC_H: src_h_q <= cfg_data_i;
          REG_DST_W: dst_w_q <= cfg_data_i;
          REG_DST_H: dst_h_q <= cfg_data_i;
        endcase
      end

      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (command_i == CMD_LOAD) begin
              if (load_wrap) begin
                load_pos_q  <= '0;
                store_pos_q <= '0;
              end else begin
                load_pos_q  <= LW'(load_next);
                store_pos_q <= (store_pos_q == STORE_M1) ? '0 : store_pos_q + SAW'(1);
              end
            end else if (col_q == '0 && row_q == '0) begin
              x_acc_q   <= '0;
              y_acc_q   <= '0;
              div_rem_q <= '0;
              div_dvd_q <= NW'({sw, {FRAC_BITS{1'b0}}});
              div_cnt_q <= NCW'(NW);
              state_q   <= ST_DIV_X;
            end else begin
              state_q <= ST_CLAMP;
            end
          end
        end
        ST_DIV_X, ST_DIV_Y: begin
          div_quo_q <= quo_d;
          div_dvd_q <= {div_dvd_q[NW-2:0], 1'b0};
          div_rem_q <= rem_d;
          div_cnt_q <= div_cnt_q - NCW'(1);
          if (div_cnt_q == NCW'(1)) begin
            if (state_q == ST_DIV_X) begin
              x_step_q  <= step_d;
              div_rem_q <= '0;
              div_dvd_q <= NW'({sh, {FRAC_BITS{1'b0}}});
              div_cnt_q <= NCW'(NW);
              state_q   <= ST_DIV_Y;
            end else begin
              y_step_q <= step_d;
              state_q  <= ST_CLAMP;
            end
          end
        end
        ST_CLAMP: begin
          sx_q    <= CW'((sx_raw > sw_m1) ? sw_m1 : sx_raw);
          sy_q    <= CW'((sy_raw > sh_m1) ? sh_m1 : sy_raw);
          state_q <= ST_ADDR;
        end
        ST_ADDR: begin
          if (NEED_MOD) begin
            div_rem_q <= '0;
            div_dvd_q <= NW'(lin) << (NW - LW);
            div_cnt_q <= NCW'(LW);
            state_q   <= ST_MOD;
          end else begin
            addr_q  <= SAW'(lin);
            state_q <= ST_READ;
          end
        end
        ST_MOD: begin
          div_dvd_q <= {div_dvd_q[NW-2:0], 1'b0};
          div_rem_q <= rem_d;
          div_cnt_q <= div_cnt_q - NCW'(1);
          if (div_cnt_q == NCW'(1)) begin
            addr_q  <= SAW'(rem_d);
            state_q <= ST_READ;
          end
        end
        ST_READ: begin
          state_q <= ST_RESULT;
        end
        ST_RESULT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            pixel_out_q <= rd_q;
            out_col_q   <= POS_W'(col_q);
            out_row_q   <= POS_W'(row_q);
            row_end_q   <= last_col;
            frame_end_q <= last_col && last_row;
            if (last_col) begin
              col_q   <= '0;
              x_acc_q <= '0;
              if (last_row) begin
                row_q   <= '0;
                y_acc_q <= '0;
              end else begin
                row_q   <= row_q + CW'(1);
                y_acc_q <= y_acc_q + y_step_q;
              end
            end else begin
              col_q   <= col_q + CW'(1);
              x_acc_q <= x_acc_q + x_step_q;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_out_o  = pixel_out_q;
  assign out_column_o = out_col_q;
  assign out_row_o    = out_row_q;
  assign row_end_o    = row_end_q;
  assign frame_end_o  = frame_end_q;

endmodule
